// ----- hw/rtl/bal_pkg.sv -----
// ----------------------------------------------------------------------------
// Barometric altitude package
// Shared widths, fixed-point constants, reciprocal tables and request types.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int PW  = 24;  // pressure width
  localparam int AW  = 21;  // altitude width
  localparam int LNW = 37;  // ln() result, Q32, unsigned
  localparam int YW  = 36;  // exp() argument, Q32, signed
  localparam int EW  = 38;  // exp() result, Q32, unsigned

  localparam int DIV_PER   = 2;   // quotient bits per divider stage
  localparam int DIV_STG   = 16;  // divider stages (32 quotient bits)
  localparam int LN_TERMS  = 12;  // atanh series terms
  localparam int EXP_STG   = 13;  // Taylor terms two to fourteen

  localparam logic [31:0] LN2_Q32   = 32'hB17217F8;
  localparam logic [27:0] EXPO_Q30  = 28'd204333069;
  localparam logic [19:0] ALT_SCALE = 20'd709280;
  localparam logic [23:0] SEA_RESET = 24'd6484800;

  typedef struct packed {
    logic vld;  // request present in this stage
    logic ok;   // both pressures nonzero
  } bal_tag_t;

  typedef struct packed {
    logic signed [AW-1:0] altitude;
    logic                 valid_res;
  } bal_res_t;

  // ceil(2^36 / (2j+1)); exact floor division of values below 2^31
  function automatic logic [34:0] ln_recip(input int j);
    logic [34:0] m;
    case (j)
      1:       m = 35'd22906492246;
      2:       m = 35'd13743895348;
      3:       m = 35'd9817068106;
      4:       m = 35'd7635497416;
      5:       m = 35'd6247225158;
      6:       m = 35'd5286113596;
      7:       m = 35'd4581298450;
      8:       m = 35'd4042322161;
      9:       m = 35'd3616814566;
      10:      m = 35'd3272355083;
      11:      m = 35'd2987803337;
      default: m = 35'd0;
    endcase
    return m;
  endfunction

  // ceil(2^36 / k); exact floor division of values below 2^32
  function automatic logic [35:0] exp_recip(input int k);
    logic [35:0] m;
    case (k)
      2:       m = 36'd34359738368;
      3:       m = 36'd22906492246;
      4:       m = 36'd17179869184;
      5:       m = 36'd13743895348;
      6:       m = 36'd11453246123;
      7:       m = 36'd9817068106;
      8:       m = 36'd8589934592;
      9:       m = 36'd7635497416;
      10:      m = 36'd6871947674;
      11:      m = 36'd6247225158;
      12:      m = 36'd5726623062;
      13:      m = 36'd5286113596;
      14:      m = 36'd4908534053;
      default: m = 36'd0;
    endcase
    return m;
  endfunction

  function automatic logic [LNW-1:0] ln2_times(input logic [4:0] k);
    return LNW'(k) * LNW'(LN2_Q32);
  endfunction

  function automatic logic signed [YW-1:0] lnmul(input logic signed [3:0] n);
    logic signed [YW-1:0] l;
    l = YW'(LN2_Q32);
    return YW'(n) * l;
  endfunction

endpackage

// ----- hw/rtl/barometric_altitude_unit.sv -----
// ----------------------------------------------------------------------------
// Barometric altitude unit
// Altitude = 44330 m * (1 - (p / p0)^0.1903) in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid/in_ready carries one pressure request (1/64 Pa).
//   Output channel out_valid/out_ready returns altitude (1/16 m, signed,
//   saturated) and out_valid_res, low with altitude zero when either
//   pressure is zero.
//   cfg_wr_en/cfg_wr_data load the sea-level pressure; write it only while
//   no request is in flight. Reset loads 101325 Pa.
// Timing:
//   A request enters every cycle while in_ready is high and passes through the
//   two 31-stage logarithm pipelines, the 29-stage exponential pipeline and
//   the scaling stages around them.
//   Throughput is one request per cycle while the pipeline is not held.
// Stalls:
//   A two-entry queue holds finished results. While it has room the pipeline
//   advances and takes new requests even if a result is waiting; when it is
//   full and out_ready is low, the whole pipeline holds and in_ready drops.
//   Reset clears every valid bit and the queue.
// ----------------------------------------------------------------------------
module barometric_altitude_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bal_pkg::PW-1:0]        in_pressure,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [bal_pkg::AW-1:0] out_altitude,
  output logic                          out_valid_res,
  input  logic                          cfg_wr_en,
  input  logic [bal_pkg::PW-1:0]        cfg_wr_data
);
  import bal_pkg::*;

  logic           en;
  logic [PW-1:0]  sea_r;
  bal_tag_t       tag_in;
  bal_tag_t       lnp_tag;
  bal_tag_t       lns_tag;
  logic [LNW-1:0] lnp;
  logic [LNW-1:0] lns;

  // sea-level reference register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sea_r <= SEA_RESET;
    end else if (cfg_wr_en) begin
      sea_r <= cfg_wr_data;
    end
  end

  // the whole pipeline advances together; hold when the queue is full
  assign in_ready   = en;
  assign tag_in.vld = in_valid && en;
  assign tag_in.ok  = (in_pressure != '0) && (sea_r != '0);

  // both logarithms run side by side
  bal_ln u_lnp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_in (tag_in),
    .x_in   (in_pressure),
    .tag_out(lnp_tag),
    .ln_out (lnp)
  );

  bal_ln u_lns (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_in (tag_in),
    .x_in   (sea_r),
    .tag_out(lns_tag),
    .ln_out (lns)
  );

  // log ratio magnitude and sign
  bal_tag_t       t1_r;
  logic           neg1_r;
  logic [LNW-1:0] mag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
    end else if (en) begin
      t1_r <= lnp_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= (lnp < lns);
      mag1_r <= (lnp < lns) ? (lns - lnp) : (lnp - lns);
    end
  end

  // scale by the exponent 0.1903 (Q30)
  bal_tag_t    t2_r;
  logic        neg2_r;
  logic [64:0] prod2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_r <= '0;
    end else if (en) begin
      t2_r <= t1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r  <= neg1_r;
      prod2_r <= 65'(mag1_r) * 65'(EXPO_Q30);
    end
  end

  // round magnitude to Q32, restore sign
  logic [64:0]          ysum;
  logic signed [YW-1:0] yv;
  bal_tag_t             t3_r;
  logic signed [YW-1:0] y3_r;

  assign ysum = prod2_r + (65'd1 << 29);
  assign yv   = $signed({1'b0, ysum[64:30]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_r <= '0;
    end else if (en) begin
      t3_r <= t2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) y3_r <= neg2_r ? -yv : yv;
  end

  bal_tag_t      ex_tag;
  logic [EW-1:0] ex_e;

  bal_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_in (t3_r),
    .y_in   (y3_r),
    .tag_out(ex_tag),
    .e_out  (ex_e)
  );

  // 1 - power, as magnitude and sign
  localparam logic [EW-1:0] ONE_E = EW'(64'h1_0000_0000);

  bal_tag_t      tf1_r;
  logic          fneg1_r;
  logic [EW-1:0] fmag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tf1_r <= '0;
    end else if (en) begin
      tf1_r <= ex_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fneg1_r <= (ex_e > ONE_E);
      fmag1_r <= (ex_e > ONE_E) ? (ex_e - ONE_E) : (ONE_E - ex_e);
    end
  end

  // scale to 1/16 m
  bal_tag_t    tf2_r;
  logic        fneg2_r;
  logic [57:0] fprod2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tf2_r <= '0;
    end else if (en) begin
      tf2_r <= tf1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fneg2_r  <= fneg1_r;
      fprod2_r <= 58'(fmag1_r) * 58'(ALT_SCALE);
    end
  end

  // round, saturate, drop invalid requests to zero
  logic [57:0] rsum;
  logic [25:0] rnd;
  bal_res_t    res;
  logic        push;
  bal_res_t    q_data;

  always_comb begin
    rsum = fprod2_r + 58'h0_8000_0000;
    rnd  = rsum[57:32];
    res.valid_res = tf2_r.ok;
    if (!tf2_r.ok) begin
      res.altitude = '0;
    end else if (!fneg2_r) begin
      res.altitude = (rnd > 26'd1048575) ? AW'(21'sd1048575) : AW'(rnd);
    end else begin
      res.altitude = (rnd > 26'd1048576) ? AW'(-22'sd1048576) : AW'(-rnd);
    end
  end

  assign push = tf2_r.vld && en;

  bal_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(res),
    .room     (en),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (q_data)
  );

  assign out_altitude  = q_data.altitude;
  assign out_valid_res = q_data.valid_res;

  // both logarithm lanes carry the same request
  a_lanes_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    lnp_tag.vld == lns_tag.vld)
    else $error("logarithm lanes out of step");

  // an invalid result always reads as zero altitude
  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_altitude == '0))
    else $error("invalid result carries nonzero altitude");

  // the pipeline only holds when a result is waiting to be taken
  a_hold_has_result : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("pipeline held with no waiting result");

endmodule

// ----- hw/rtl/bal_ln.sv -----
// ----------------------------------------------------------------------------
// Natural logarithm pipeline
// Leading-one normalise, radix-2 divide, then a twelve-term atanh series.
// ----------------------------------------------------------------------------
module bal_ln (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  bal_pkg::bal_tag_t      tag_in,
  input  logic [bal_pkg::PW-1:0] x_in,
  output bal_pkg::bal_tag_t      tag_out,
  output logic [bal_pkg::LNW-1:0] ln_out
);
  import bal_pkg::*;

  logic [4:0]  k_nxt;
  logic [22:0] n_nxt;
  logic [24:0] d_nxt;

  always_comb begin
    k_nxt = '0;
    for (int b = 0; b < PW; b++) begin
      if (x_in[b]) k_nxt = 5'(b);
    end
    n_nxt = 23'(x_in - (24'd1 << k_nxt));
    d_nxt = 25'(x_in) + (25'd1 << k_nxt);
  end

  bal_tag_t    tdv_r  [0:DIV_STG];
  logic [4:0]  kdv_r  [0:DIV_STG];
  logic [24:0] ddv_r  [0:DIV_STG];
  logic [24:0] rem_r  [0:DIV_STG];
  logic [31:0] quo_r  [0:DIV_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdv_r[0] <= '0;
    end else if (en) begin
      tdv_r[0] <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kdv_r[0] <= k_nxt;
      ddv_r[0] <= d_nxt;
      rem_r[0] <= {2'b00, n_nxt};
      quo_r[0] <= '0;
    end
  end

  // restoring division, two quotient bits per stage
  for (genvar i = 1; i <= DIV_STG; i++) begin : g_div
    logic [24:0] rem_nxt;
    logic [31:0] quo_nxt;
    logic [25:0] sh;

    always_comb begin
      rem_nxt = rem_r[i-1];
      quo_nxt = quo_r[i-1];
      sh      = '0;
      for (int st = 0; st < DIV_PER; st++) begin
        sh = {rem_nxt, 1'b0};
        if (sh >= {1'b0, ddv_r[i-1]}) begin
          rem_nxt = 25'(sh - {1'b0, ddv_r[i-1]});
          quo_nxt = {quo_nxt[30:0], 1'b1};
        end else begin
          rem_nxt = sh[24:0];
          quo_nxt = {quo_nxt[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tdv_r[i] <= '0;
      end else if (en) begin
        tdv_r[i] <= tdv_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        kdv_r[i] <= kdv_r[i-1];
        ddv_r[i] <= ddv_r[i-1];
        rem_r[i] <= rem_nxt;
        quo_r[i] <= quo_nxt;
      end
    end
  end

  // series: s = sum u^(2j+1) / (2j+1)
  bal_tag_t    tsr_r [0:LN_TERMS];
  logic [4:0]  ksr_r [0:LN_TERMS];
  logic [31:0] pw_r  [0:LN_TERMS-1];
  logic [31:0] u2_r  [0:LN_TERMS-2];
  logic [31:0] qt_r  [0:LN_TERMS];
  logic [32:0] s_r   [0:LN_TERMS];
  logic [63:0] usq;

  assign usq = 64'(quo_r[DIV_STG]) * 64'(quo_r[DIV_STG]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsr_r[0] <= '0;
    end else if (en) begin
      tsr_r[0] <= tdv_r[DIV_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ksr_r[0] <= kdv_r[DIV_STG];
      pw_r[0]  <= quo_r[DIV_STG];
      u2_r[0]  <= usq[63:32];
      qt_r[0]  <= '0;
      s_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < LN_TERMS; j++) begin : g_term
    logic [66:0] qp;

    assign qp = 67'(pw_r[j]) * 67'(ln_recip(j));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tsr_r[j+1] <= '0;
      end else if (en) begin
        tsr_r[j+1] <= tsr_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ksr_r[j+1] <= ksr_r[j];
        s_r[j+1]   <= s_r[j] + 33'(qt_r[j]);
        qt_r[j+1]  <= (j == 0) ? pw_r[j] : 32'(qp[66:36]);
      end
    end

    if (j < LN_TERMS - 1) begin : g_pw
      logic [63:0] pp;
      assign pp = 64'(pw_r[j]) * 64'(u2_r[j]);
      always_ff @(posedge clk) begin
        if (en) pw_r[j+1] <= pp[63:32];
      end
      if (j < LN_TERMS - 2) begin : g_u2
        always_ff @(posedge clk) begin
          if (en) u2_r[j+1] <= u2_r[j];
        end
      end
    end
  end

  logic [32:0]    s_fin;
  bal_tag_t       tfin_r;
  logic [LNW-1:0] ln_r;

  assign s_fin = s_r[LN_TERMS] + 33'(qt_r[LN_TERMS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tfin_r <= '0;
    end else if (en) begin
      tfin_r <= tsr_r[LN_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) ln_r <= ln2_times(ksr_r[LN_TERMS]) + LNW'({s_fin, 1'b0});
  end

  assign tag_out = tfin_r;
  assign ln_out  = ln_r;

endmodule

// ----- hw/rtl/bal_exp.sv -----
// ----------------------------------------------------------------------------
// Exponential pipeline
// Reduce by ln 2, Taylor series through the fourteenth power, scale by the power of two.
// ----------------------------------------------------------------------------
module bal_exp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  bal_pkg::bal_tag_t            tag_in,
  input  logic signed [bal_pkg::YW-1:0] y_in,
  output bal_pkg::bal_tag_t            tag_out,
  output logic [bal_pkg::EW-1:0]       e_out
);
  import bal_pkg::*;

  // n = floor(y / ln2), y known to lie in [-5 ln2, 5 ln2)
  logic [3:0]        cnt;
  logic signed [3:0] n_nxt;

  always_comb begin
    cnt = '0;
    for (int j = -4; j <= 4; j++) begin
      if (y_in >= lnmul(4'(j))) cnt = cnt + 4'd1;
    end
    n_nxt = $signed(cnt) - 4'sd5;
  end

  bal_tag_t             t0_r;
  logic signed [YW-1:0] y0_r;
  logic signed [3:0]    n0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_r <= '0;
    end else if (en) begin
      t0_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y0_r <= y_in;
      n0_r <= n_nxt;
    end
  end

  logic signed [YW-1:0] rfull;
  assign rfull = y0_r - lnmul(n0_r);

  // B-side arrays hold term k-1 and the running sum; A-side the raw product
  bal_tag_t          tb_r    [0:EXP_STG];
  logic signed [3:0] nb_r    [0:EXP_STG];
  logic [31:0]       term_r  [0:EXP_STG];
  logic [33:0]       sum_r   [0:EXP_STG];
  logic [31:0]       r_r     [0:EXP_STG-1];
  bal_tag_t          ta_r    [0:EXP_STG-1];
  logic signed [3:0] na_r    [0:EXP_STG-1];
  logic [31:0]       p_r     [0:EXP_STG-1];
  logic [33:0]       suma_r  [0:EXP_STG-1];
  logic [31:0]       ra_r    [0:EXP_STG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r[0] <= '0;
    end else if (en) begin
      tb_r[0] <= t0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nb_r[0]   <= n0_r;
      term_r[0] <= rfull[31:0];
      r_r[0]    <= rfull[31:0];
      sum_r[0]  <= 34'h1_0000_0000;
    end
  end

  for (genvar i = 0; i < EXP_STG; i++) begin : g_tay
    logic [63:0] pm;
    logic [67:0] qm;

    assign pm = 64'(term_r[i]) * 64'(r_r[i]);
    assign qm = 68'(p_r[i]) * 68'(exp_recip(i + 2));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ta_r[i]   <= '0;
        tb_r[i+1] <= '0;
      end else if (en) begin
        ta_r[i]   <= tb_r[i];
        tb_r[i+1] <= ta_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        na_r[i]     <= nb_r[i];
        p_r[i]      <= pm[63:32];
        suma_r[i]   <= sum_r[i] + 34'(term_r[i]);
        ra_r[i]     <= r_r[i];
        nb_r[i+1]   <= na_r[i];
        term_r[i+1] <= qm[67:36];
        sum_r[i+1]  <= suma_r[i];
      end
    end

    if (i < EXP_STG - 1) begin : g_r
      always_ff @(posedge clk) begin
        if (en) r_r[i+1] <= ra_r[i];
      end
    end
  end

  logic [33:0]   sum_f;
  logic [EW-1:0] e_nxt;
  bal_tag_t      tf_r;
  logic [EW-1:0] e_r;

  always_comb begin
    sum_f = sum_r[EXP_STG] + 34'(term_r[EXP_STG]);
    if (!nb_r[EXP_STG][3]) begin
      e_nxt = EW'(sum_f) << nb_r[EXP_STG][2:0];
    end else begin
      e_nxt = EW'(sum_f) >> 3'(-nb_r[EXP_STG]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tf_r <= '0;
    end else if (en) begin
      tf_r <= tb_r[EXP_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) e_r <= e_nxt;
  end

  assign tag_out = tf_r;
  assign e_out   = e_r;

endmodule

// ----- hw/rtl/bal_outq.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue parting the pipeline from the result channel.
// ----------------------------------------------------------------------------
module bal_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bal_pkg::bal_res_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output bal_pkg::bal_res_t out_data
);
  import bal_pkg::*;

  bal_res_t   mem_r [0:1];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign pop     = (cnt_r != 2'd0) && out_ready;
  assign room    = (cnt_r != 2'd2) || out_ready;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rp_r];

endmodule
